FILE: rtl/efd_pkg.sv
// Package for the escaped frame deframer.
// Holds the transfer payload types, the escape codes and the escape table.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package efd_pkg;

    // Limits of the stored frame length.
    localparam int unsigned MAX_LEN = 1024;
    localparam int unsigned MIN_LEN = 3;
    localparam int unsigned LEN_W   = 11;

    // Output queue depth and its index widths.
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = 2;
    localparam int unsigned QCNT_W  = 3;

    // Configuration port.
    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_MAX_FRAME_LEN = 3'd0;

    // Input item kinds.
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    // Result kinds.
    localparam logic [1:0] OUT_DATA    = 2'd0;
    localparam logic [1:0] OUT_END     = 2'd1;
    localparam logic [1:0] OUT_ABORT   = 2'd2;
    localparam logic [1:0] OUT_DROPPED = 2'd3;

    // Raw line codes.
    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] OPEN_CODE  = 8'h07;
    localparam logic [7:0] CLOSE_CODE = 8'h08;
    localparam logic [7:0] LAST_ESC   = 8'h06;

    typedef struct packed {
        logic       kind;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       out_kind;
        logic [7:0]       out_byte;
        logic [LEN_W-1:0] frame_len;
        logic             last;
    } out_item_t;

    // Results handed together from the decoder to the output queue.
    typedef struct packed {
        logic [1:0] num;
        out_item_t  r0;
        out_item_t  r1;
    } push_t;

    // Decoded value of an escape code 00..06.
    function automatic logic [7:0] esc_decode(input logic [2:0] code);
        logic [7:0] val;
        case (code)
            3'd0:    val = 8'h7E;
            3'd1:    val = 8'h24;
            3'd2:    val = 8'h23;
            3'd3:    val = 8'h25;
            3'd4:    val = 8'hA4;
            3'd5:    val = 8'hA3;
            3'd6:    val = 8'hA5;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/efd_cfg.sv
// APB-style configuration register for the deframer.
// Holds max_frame_len and provides the clamped length limit; uses efd_pkg.
`default_nettype none

module efd_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [efd_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    output logic      [efd_pkg::LEN_W-1:0]        limit
);

    logic [efd_pkg::LEN_W-1:0] max_len_reg;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == efd_pkg::ADDR_MAX_FRAME_LEN);

    // Register write at the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= efd_pkg::LEN_W'(efd_pkg::MAX_LEN);
        end
        else if (wr_en)
        begin
            max_len_reg <= pwdata[efd_pkg::LEN_W-1:0];
        end
    end

    // Read data.
    always_comb
    begin
        prdata = '0;
        if (paddr == efd_pkg::ADDR_MAX_FRAME_LEN)
        begin
            prdata = {{(32-efd_pkg::LEN_W){1'b0}}, max_len_reg};
        end
    end

    // Clamp the limit into its legal range.
    always_comb
    begin
        if (max_len_reg < efd_pkg::LEN_W'(efd_pkg::MIN_LEN))
        begin
            limit = efd_pkg::LEN_W'(efd_pkg::MIN_LEN);
        end
        else if (max_len_reg > efd_pkg::LEN_W'(efd_pkg::MAX_LEN))
        begin
            limit = efd_pkg::LEN_W'(efd_pkg::MAX_LEN);
        end
        else
        begin
            limit = max_len_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/efd_decoder.sv
// Input register and frame decoder of the deframer.
// Holds the framing state and turns one item into up to two results; uses efd_pkg.
`default_nettype none

module efd_decoder (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire efd_pkg::in_item_t          in_data,
    input  wire logic [efd_pkg::LEN_W-1:0]  limit,
    input  wire logic                       room,
    output efd_pkg::push_t                  push
);

    logic                      stg_valid_reg;
    efd_pkg::in_item_t         stg_item_reg;
    logic                      in_frame_reg;
    logic                      in_frame_next;
    logic                      pend_reg;
    logic                      pend_next;
    logic                      saw_reg;
    logic                      saw_next;
    logic [efd_pkg::LEN_W-1:0] cnt_reg;
    logic [efd_pkg::LEN_W-1:0] cnt_next;
    logic [efd_pkg::LEN_W-1:0] cnt_inc;
    logic                      adv;
    logic                      full;
    logic                      full2;
    logic [7:0]                b;
    logic [1:0]                n;
    efd_pkg::out_item_t        r0;
    efd_pkg::out_item_t        r1;

    // The staged item moves on once the queue can take two results.
    assign adv      = stg_valid_reg && room;
    assign in_ready = !stg_valid_reg || room;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            stg_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stg_item_reg <= in_data;
        end
    end

    // Framing state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pend_reg     <= 1'b0;
            saw_reg      <= 1'b0;
            cnt_reg      <= '0;
        end
        else if (adv)
        begin
            in_frame_reg <= in_frame_next;
            pend_reg     <= pend_next;
            saw_reg      <= saw_next;
            cnt_reg      <= cnt_next;
        end
    end

    assign b       = stg_item_reg.in_byte;
    assign cnt_inc = cnt_reg + efd_pkg::LEN_W'(1);
    assign full    = (cnt_reg >= limit);
    assign full2   = (cnt_inc >= limit);

    // Decode one item against the state.
    always_comb
    begin
        in_frame_next = in_frame_reg;
        pend_next     = pend_reg;
        saw_next      = saw_reg;
        cnt_next      = cnt_reg;
        n             = 2'd0;
        r0            = '0;
        r1            = '0;

        if (stg_item_reg.kind == efd_pkg::KIND_TIMEOUT)
        begin
            if (in_frame_reg)
            begin
                n            = 2'd1;
                r0.out_kind  = efd_pkg::OUT_DROPPED;
                r0.frame_len = cnt_reg;
            end
            in_frame_next = 1'b0;
            pend_next     = 1'b0;
            saw_next      = 1'b0;
            cnt_next      = '0;
        end
        else if (!in_frame_reg)
        begin
            // Hunting for the opening pair.
            if (saw_reg && (b == efd_pkg::OPEN_CODE))
            begin
                in_frame_next = 1'b1;
                pend_next     = 1'b0;
                saw_next      = 1'b0;
                cnt_next      = '0;
            end
            else
            begin
                saw_next = (b == efd_pkg::FLAG_BYTE);
            end
        end
        else if (pend_reg && (b == efd_pkg::CLOSE_CODE))
        begin
            // Frame closes normally.
            n             = 2'd1;
            r0.out_kind   = efd_pkg::OUT_END;
            r0.frame_len  = cnt_reg;
            in_frame_next = 1'b0;
            pend_next     = 1'b0;
            saw_next      = 1'b0;
            cnt_next      = '0;
        end
        else if (!pend_reg && (b == efd_pkg::FLAG_BYTE))
        begin
            pend_next = 1'b1;
        end
        else
        begin
            // One decoded byte to store first.
            n = 2'd1;
            if (full)
            begin
                r0.out_kind   = efd_pkg::OUT_ABORT;
                r0.frame_len  = cnt_reg;
                in_frame_next = 1'b0;
                pend_next     = 1'b0;
                saw_next      = 1'b0;
                cnt_next      = '0;
            end
            else
            begin
                r0.out_kind = efd_pkg::OUT_DATA;
                cnt_next    = cnt_inc;
                if (!pend_reg)
                begin
                    r0.out_byte = b;
                end
                else if (b <= efd_pkg::LAST_ESC)
                begin
                    r0.out_byte = efd_pkg::esc_decode(b[2:0]);
                    pend_next   = 1'b0;
                end
                else if (b == efd_pkg::FLAG_BYTE)
                begin
                    // Double flag: the first is data, the second stays pending.
                    r0.out_byte = efd_pkg::FLAG_BYTE;
                end
                else
                begin
                    // Unknown escape keeps both raw bytes.
                    r0.out_byte = efd_pkg::FLAG_BYTE;
                    pend_next   = 1'b0;
                    n           = 2'd2;
                    if (full2)
                    begin
                        r1.out_kind   = efd_pkg::OUT_ABORT;
                        r1.frame_len  = cnt_inc;
                        in_frame_next = 1'b0;
                        saw_next      = 1'b0;
                        cnt_next      = '0;
                    end
                    else
                    begin
                        r1.out_kind = efd_pkg::OUT_DATA;
                        r1.out_byte = b;
                        cnt_next    = cnt_reg + efd_pkg::LEN_W'(2);
                    end
                end
            end
        end

        // Mark the final result of the item.
        if (n == 2'd1)
        begin
            r0.last = 1'b1;
        end
        else if (n == 2'd2)
        begin
            r1.last = 1'b1;
        end
    end

    assign push.num = adv ? n : 2'd0;
    assign push.r0  = r0;
    assign push.r1  = r1;

endmodule

`default_nettype wire

FILE: rtl/efd_out_queue.sv
// Result queue of the deframer: four entries, two writes and one read a cycle.
// Parts the decoder from the output handshake; uses efd_pkg.
`default_nettype none

module efd_out_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire efd_pkg::push_t      push,
    output logic                     room,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output efd_pkg::out_item_t       out_data
);

    efd_pkg::out_item_t          mem_reg [efd_pkg::QDEPTH];
    logic [efd_pkg::QPTR_W-1:0]  head_reg;
    logic [efd_pkg::QPTR_W-1:0]  tail_reg;
    logic [efd_pkg::QPTR_W-1:0]  tail_p1;
    logic [efd_pkg::QCNT_W-1:0]  count_reg;
    logic [efd_pkg::QCNT_W-1:0]  count_next;
    logic                        pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[head_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= efd_pkg::QCNT_W'(efd_pkg::QDEPTH - 2));
    assign tail_p1   = tail_reg + efd_pkg::QPTR_W'(1);

    assign count_next = count_reg + efd_pkg::QCNT_W'(push.num)
                        - efd_pkg::QCNT_W'(pop);

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                head_reg <= head_reg + efd_pkg::QPTR_W'(1);
            end
            tail_reg  <= tail_reg + efd_pkg::QPTR_W'(push.num);
            count_reg <= count_next;
        end
    end

    // Entry writes.
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem_reg[tail_reg] <= push.r0;
        end
        if (push.num == 2'd2)
        begin
            mem_reg[tail_p1] <= push.r1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/escaped_frame_deframer.sv
// Top level of the escaped frame deframer.
// Ties together efd_cfg, efd_decoder and efd_out_queue; uses efd_pkg.
//
//   Channel   Direction  Handshake                  Payload
//   in        sink       in_valid / in_ready        in_data   (kind, in_byte)
//   out       source     out_valid / out_ready      out_data  (out_kind, out_byte,
//                                                             frame_len, last)
//   cfg       APB slave  psel, penable, pwrite      paddr, pwdata, prdata
//
// An item is registered on acceptance and decoded from that register; when the
// queue has room, it writes zero, one or two results into a four-entry queue.
// One item is taken every cycle while the queue holds at most two results;
// the one-result-per-cycle output port sets the rate for items that give two.
// A result passes the input register and then the result queue to the output.
// Reset clears the framing state to hunting and empties the queue.
`default_nettype none

module escaped_frame_deframer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire efd_pkg::in_item_t            in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output efd_pkg::out_item_t                out_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [efd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    logic [efd_pkg::LEN_W-1:0] limit;
    logic                      room;
    efd_pkg::push_t            push;

    // Configuration register.
    efd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limit   (limit)
    );

    // Input register and decoder.
    efd_decoder u_decoder (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .limit    (limit),
        .room     (room),
        .push     (push)
    );

    // Result queue.
    efd_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/efd_checker.sv
// Port-level checker for the escaped frame deframer, bound to the top level.
// Sees only the top-level ports; uses efd_pkg.
`default_nettype none

module efd_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire efd_pkg::out_item_t           out_data,
    input  wire logic                         pready
);

    // A result that is not taken stays unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transfer changed while stalled");

    // End, abort and drop results always close the item's results.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.out_kind != efd_pkg::OUT_DATA) |-> out_data.last)
        else $error("status result not marked last");

    // Data results carry no length, status results carry no byte.
    a_field_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.out_kind == efd_pkg::OUT_DATA)
                       ? (out_data.frame_len == '0) : (out_data.out_byte == 8'h00)))
        else $error("unused result field not zero");

    // The reported length never passes the largest limit.
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.frame_len <= efd_pkg::LEN_W'(efd_pkg::MAX_LEN)))
        else $error("frame length beyond limit");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind escaped_frame_deframer efd_checker u_efd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .pready    (pready)
);

`default_nettype wire
